/* hw/rtl/gdd_pkg.sv */
// Shared types, widths and constants for the Gregorian day difference block.
// No dependencies; imported by gdd_ordinal, gregorian_day_difference and its testbench.
package gdd_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int ORD_W  = 23;   // day ordinal of a date, years up to 16383
  localparam int DIST_W = 22;
  localparam int MBD_W  = 9;    // days before a month, at most 334

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // ceil(y / 100) = ((y + 99) * RECIP_100) >> RECIP_SHIFT, exact for y + 99 < 2^15
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = 28;
  localparam int Q100_W      = 8;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } date_t;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'b00,
    ORD_LATER   = 2'b01,
    ORD_EARLIER = 2'b11
  } order_t;

  // Days in the months before the given one, non-leap year.
  // Month zero counts nothing; months above twelve count like December.
  function automatic logic [MBD_W-1:0] days_before_month(input logic [MON_W-1:0] m);
    logic [MBD_W-1:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      default:    r = 9'd334;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/gdd_ordinal.sv */
// Three-stage pipeline mapping one date to its day ordinal since year zero.
// Depends on gdd_pkg; the caller supplies the shared stall enable.
module gdd_ordinal
  import gdd_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  date_t            date_i,
  output logic [ORD_W-1:0] ordinal_o
);

  localparam int Y1_W = YEAR_W + 1;

  // Stage a: constant multiplies
  date_t              a_date_r;
  logic [ORD_W-1:0]   a_y365_r;
  logic [PROD_W-1:0]  a_prod_r;
  logic [YEAR_W-2:0]  a_ceil4_r;

  logic [Y1_W-1:0]    y99;
  logic [Y1_W-1:0]    y3;

  assign y99 = Y1_W'(date_i.year) + Y1_W'(99);
  assign y3  = Y1_W'(date_i.year) + Y1_W'(3);

  always_ff @(posedge clk) begin
    if (en) begin
      a_date_r  <= date_i;
      a_y365_r  <= ORD_W'(date_i.year) * ORD_W'(365);
      a_prod_r  <= PROD_W'(y99) * PROD_W'(RECIP_100);
      a_ceil4_r <= y3[Y1_W-1:2];
    end
  end

  // Stage b: century count, leap test, partial year sum
  date_t              b_date_r;
  logic [ORD_W-1:0]   b_base_r;
  logic [Q100_W-1:0]  b_q100_r;
  logic               b_leap_r;

  logic [Q100_W-1:0]  q100;
  logic [Y1_W-1:0]    q100_x100;
  logic               div100;
  logic               leap;

  assign q100      = a_prod_r[RECIP_SHIFT +: Q100_W];
  assign q100_x100 = Y1_W'(q100) * Y1_W'(100);
  assign div100    = (q100_x100 == Y1_W'(a_date_r.year));
  // divisible by 4, and either not by 100 or also by 400
  assign leap      = (a_date_r.year[1:0] == 2'b00) && (!div100 || (q100[1:0] == 2'b00));

  always_ff @(posedge clk) begin
    if (en) begin
      b_date_r <= a_date_r;
      b_base_r <= a_y365_r + ORD_W'(a_ceil4_r);
      b_q100_r <= q100;
      b_leap_r <= leap;
    end
  end

  // Stage c: finish the year count, add months and day
  logic [Q100_W:0]    q3;
  logic [ORD_W-1:0]   ord_nxt;
  logic [ORD_W-1:0]   ord_r;
  logic               leap_add;

  assign q3       = (Q100_W+1)'(b_q100_r) + (Q100_W+1)'(3);
  assign leap_add = b_leap_r && (b_date_r.month > MON_W'(2));
  assign ord_nxt  = b_base_r - ORD_W'(b_q100_r) + ORD_W'(q3[Q100_W:2])
                  + ORD_W'(days_before_month(b_date_r.month))
                  + ORD_W'(leap_add) + ORD_W'(b_date_r.day);

  always_ff @(posedge clk) begin
    if (en) begin
      ord_r <= ord_nxt;
    end
  end

  assign ordinal_o = ord_r;

endmodule

/* hw/rtl/gregorian_day_difference.sv */
// Top level: days between two Gregorian dates, plus their order.
// Depends on gdd_pkg and gdd_ordinal (one instance per date).
//
// Usage:
//   in_*  : one word per date pair (day, month, year of each date).
//   out_* : one word per pair: saturated absolute day distance and order
//           (1 first later, -1 first earlier, 0 equal).
//   Years above MAX_YEAR are clamped before comparing and counting.
// Timing:
//   Five register stages: clamp/compare, multiply, century/leap,
//   ordinal sum, distance/saturate. out_tvalid is the last stage's valid
//   bit and rises with the result in dist_r; one word per cycle is
//   sustained, limited only by the output side taking words.
// Reset:
//   rst_n low empties the pipeline; out_tvalid drops and in_tready rises
//   once reset is released.
// Stall:
//   While out_tvalid is high and out_tready low the whole pipeline holds,
//   in_tready is low, and no word is dropped or repeated.
module gregorian_day_difference
  import gdd_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [4:0] first_day, [8:5] first_month, [22:9] first_year,
  // [27:23] second_day, [31:28] second_month, [45:32] second_year, [47:46] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [21:0] day_distance, [23:22] order (signed)
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CMP_W = 17;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = rst_n && en;

  // Field unpacking and year clamp
  date_t d1_in, d2_in, d1, d2;

  assign d1_in.day   = in_tdata[4:0];
  assign d1_in.month = in_tdata[8:5];
  assign d1_in.year  = in_tdata[22:9];
  assign d2_in.day   = in_tdata[27:23];
  assign d2_in.month = in_tdata[31:28];
  assign d2_in.year  = in_tdata[45:32];

  always_comb begin
    d1 = d1_in;
    d2 = d2_in;
    if (CMP_W'(d1_in.year) > CMP_W'(MAX_YEAR)) d1.year = YEAR_W'(MAX_YEAR);
    if (CMP_W'(d2_in.year) > CMP_W'(MAX_YEAR)) d2.year = YEAR_W'(MAX_YEAR);
  end

  // Stage 1: clamped dates and their order
  date_t  s1_d1_r, s1_d2_r;
  order_t s1_ord_r, ord_nxt;

  always_comb begin
    if (d1 == d2)      ord_nxt = ORD_EQUAL;
    else if (d1 > d2)  ord_nxt = ORD_LATER;
    else               ord_nxt = ORD_EARLIER;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d1_r  <= d1;
      s1_d2_r  <= d2;
      s1_ord_r <= ord_nxt;
    end
  end

  // Stages 2 to 4: ordinal of each date
  logic [ORD_W-1:0] o1, o2;

  gdd_ordinal u_ord1 (
    .clk       (clk),
    .en        (en),
    .date_i    (s1_d1_r),
    .ordinal_o (o1)
  );

  gdd_ordinal u_ord2 (
    .clk       (clk),
    .en        (en),
    .date_i    (s1_d2_r),
    .ordinal_o (o2)
  );

  // Order travels alongside the ordinal stages
  order_t s2_ord_r, s3_ord_r, s4_ord_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ord_r <= s1_ord_r;
      s3_ord_r <= s2_ord_r;
      s4_ord_r <= s3_ord_r;
    end
  end

  // Valid bits, one per stage
  logic [4:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_tvalid};
    end
  end

  // Stage 5: absolute distance, saturated
  logic [ORD_W-1:0]  diff;
  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] dist_r;
  order_t            out_ord_r;

  assign diff     = (o1 >= o2) ? (o1 - o2) : (o2 - o1);
  assign dist_nxt = diff[ORD_W-1] ? DIST_MAX : diff[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r    <= dist_nxt;
      out_ord_r <= s4_ord_r;
    end
  end

  assign out_tvalid = vld_r[4];
  assign out_tdata  = {out_ord_r, dist_r};

  // Checks
  a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_ord_r == ORD_EQUAL) |-> (dist_r == '0))
    else $error("equal dates with nonzero distance");

  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:22] != 2'b10))
    else $error("invalid order code");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted word not in stage 1");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(vld_r) && $stable(dist_r))
    else $error("pipeline moved during stall");

endmodule

/* sim/gregorian_day_difference_test.sv */
// Self-checking testbench for gregorian_day_difference: date pairs in, day distance and order out.
// Depends on gdd_pkg and the RTL of the block; a local date arithmetic model predicts each word.
module gregorian_day_difference_test
  import gdd_pkg::*;
();

  localparam int YEAR_LIMIT   = 9999;
  localparam int RANDOM_PAIRS = 880;
  localparam int IDLE_LIMIT   = 1000;
  localparam int PRESSURE_AT  = 300;
  localparam int PRESSURE_LEN = 60;

  // non-leap days ahead of each month, January first
  localparam longint unsigned MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
                                                   273, 304, 334};

  // first date in the low bits, as on in_tdata
  typedef struct packed {
    date_t second;
    date_t first;
  } date_pair_t;

  // same layout as out_tdata
  typedef struct packed {
    order_t            rel;
    logic [DIST_W-1:0] distance;
  } day_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  date_pair_t  pending_pairs [$];
  day_result_t awaited_results [$];
  date_pair_t  offered;
  day_result_t seen_word;
  day_result_t wanted_word;

  int          mismatch_count = 0;
  int          burst_left = 8;
  int          gap_left = 0;
  int          hold_left = 0;
  int          inputs_seen = 0;
  int          idle_cycles = 0;
  bit          pressure_done = 1'b0;
  logic [31:0] rx_cycle = '0;

  gregorian_day_difference #(
    .MAX_YEAR(YEAR_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint unsigned effective_year(date_t dt);
    return (dt.year > YEAR_LIMIT) ? YEAR_LIMIT : dt.year;
  endfunction

  // days from the start of year zero; Jan 1 of year zero is day 1
  function automatic longint unsigned day_number(date_t dt);
    longint unsigned y;
    longint unsigned m;
    longint unsigned n;
    y = effective_year(dt);
    m = (dt.month > 12) ? 12 : dt.month;
    n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    if (m != 0) begin
      n += MONTH_START[m - 1];
    end
    // leap day counts once February is behind us; year zero is a leap year
    if (m > 2 && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) begin
      n += 1;
    end
    return n + dt.day;
  endfunction

  function automatic day_result_t predict_distance(date_pair_t p);
    longint unsigned ya;
    longint unsigned yb;
    longint unsigned a;
    longint unsigned b;
    longint unsigned d;
    day_result_t     r;
    ya = effective_year(p.first);
    yb = effective_year(p.second);
    // order goes field by field, so it may disagree with odd day values
    if (ya != yb) begin
      r.rel = (ya > yb) ? ORD_LATER : ORD_EARLIER;
    end else if (p.first.month != p.second.month) begin
      r.rel = (p.first.month > p.second.month) ? ORD_LATER : ORD_EARLIER;
    end else if (p.first.day != p.second.day) begin
      r.rel = (p.first.day > p.second.day) ? ORD_LATER : ORD_EARLIER;
    end else begin
      r.rel = ORD_EQUAL;
    end
    a = day_number(p.first);
    b = day_number(p.second);
    d = (a >= b) ? (a - b) : (b - a);
    if (d > DIST_MAX) begin
      d = DIST_MAX;
    end
    r.distance = d[DIST_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic date_t make_date(int unsigned d, int unsigned m, int unsigned y);
    date_t dt;
    dt.day   = d[DAY_W-1:0];
    dt.month = m[MON_W-1:0];
    dt.year  = y[YEAR_W-1:0];
    return dt;
  endfunction

  task automatic add_pair(int unsigned d1, int unsigned m1, int unsigned y1,
                          int unsigned d2, int unsigned m2, int unsigned y2);
    date_pair_t p;
    p.first  = make_date(d1, m1, y1);
    p.second = make_date(d2, m2, y2);
    pending_pairs.push_back(p);
  endtask

  function automatic date_t plain_date();
    return make_date($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1, 9999));
  endfunction

  function automatic date_t raw_date();
    return make_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------- sender

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        awaited_results.push_back(predict_distance(offered));
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        offered = pending_pairs.pop_front();
        in_tdata  <= IN_TDATA_W'(offered);
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (in_tvalid && in_tready) begin
        inputs_seen++;
      end
      // one long hold-off so the pipeline fills and pushes back on the input
      if (!pressure_done && inputs_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0:    out_tready <= 1'b1;
          2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
          2'd2:    out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= rx_cycle[2];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_word = out_tdata;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected word, day_distance", seen_word.distance, 0);
      end else begin
        wanted_word = awaited_results.pop_front();
        if (seen_word.distance !== wanted_word.distance) begin
          report_mismatch("day_distance", seen_word.distance, wanted_word.distance);
        end
        if (seen_word.rel !== wanted_word.rel) begin
          report_mismatch("order", $signed(seen_word.rel), $signed(wanted_word.rel));
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    date_pair_t p;
    int unsigned y;

    // directed: equal dates, range extremes, leap rules, clamping, odd fields
    add_pair(1, 1, 1, 1, 1, 1);
    add_pair(31, 12, 9999, 1, 1, 1);
    add_pair(1, 1, 1, 31, 12, 9999);
    add_pair(31, 15, 16383, 0, 0, 0);
    add_pair(0, 0, 0, 31, 15, 16383);
    add_pair(29, 2, 0, 1, 3, 0);
    add_pair(5, 6, 16383, 5, 6, 9999);
    add_pair(1, 1, 10000, 31, 12, 9998);
    add_pair(31, 2, 2023, 3, 3, 2023);
    add_pair(29, 2, 2000, 1, 3, 1900);
    add_pair(1, 3, 2100, 28, 2, 2100);
    add_pair(1, 3, 2024, 28, 2, 2024);
    add_pair(31, 12, 1999, 1, 1, 2000);
    add_pair(0, 5, 2020, 30, 4, 2020);
    add_pair(1, 0, 1600, 1, 1, 1600);
    add_pair(1, 13, 2001, 1, 1, 2002);
    add_pair(10, 14, 2004, 10, 15, 2004);
    add_pair(31, 1, 2400, 1, 3, 2400);
    add_pair(15, 7, 5000, 15, 7, 4999);
    add_pair(21, 10, 9362, 10, 5, 1234);
    add_pair(16, 8, 8192, 16, 8, 4096);

    // random: mostly well-formed dates, some close pairs, leap edges, raw bits
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          p.first  = plain_date();
          p.second = plain_date();
        end
        5, 6: begin
          p.first  = plain_date();
          p.second = p.first;
          case ($urandom_range(0, 3))
            0:       p.second.day   = DAY_W'($urandom_range(1, 31));
            1:       p.second.month = MON_W'($urandom_range(1, 12));
            2:       p.second.year  = YEAR_W'(p.first.year + $urandom_range(0, 2));
            default: ;
          endcase
        end
        7: begin
          y = $urandom_range(0, 99) * 100 + $urandom_range(0, 4);
          p.first  = make_date($urandom_range(28, 29), 2, y);
          p.second = make_date($urandom_range(1, 2), 3, y + $urandom_range(0, 1));
        end
        default: begin
          p.first  = raw_date();
          p.second = ($urandom_range(0, 1) == 0) ? raw_date() : plain_date();
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        pending_pairs.push_back(p);
      end else begin
        pending_pairs.push_back({p.first, p.second});
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
    end while (pending_pairs.size() != 0 || in_tvalid || awaited_results.size() != 0);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
